// ===== sv/gpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Gaussian density and CDF block.
// Used by gpc_pipe and gaussian_pdf_cdf; depends on nothing.

package gpc_pkg;

	// Register indexes of the configuration port.
	localparam logic REG_MEAN    = 1'b0;
	localparam logic REG_STD_DEV = 1'b1;

	localparam logic [30:0] STD_DEV_RESET = 31'd65536;

	// Fixed-point constants.
	localparam logic [30:0] ONE30           = 31'h4000_0000;
	localparam logic [28:0] LOG2E_Q28       = 29'd387270501;
	localparam logic [29:0] LN2_Q30         = 30'd744261118;
	localparam logic [28:0] INV_SQRT2PI_Q30 = 29'd428364559;
	localparam logic [27:0] P_Q30           = 28'd248723596;
	localparam logic [35:0] B5_Q30          = 36'sd1428371292;

	// Coefficients added after each Horner product of the tail polynomial.
	localparam logic [35:0] POLY_ADD [0:4] = '{
		-36'sd1955558716, 36'sd1912847369, -36'sd382857446, 36'sd342933307, 36'sd0
	};

	// floor(v / n) = (v * DIV_RECIP[n]) >> DIV_SHIFT[n], exact for v < 2^30.
	localparam logic [31:0] DIV_RECIP [1:10] = '{
		32'd1073741824, 32'd1073741824, 32'd1431655766, 32'd1073741824, 32'd1717986919,
		32'd1431655766, 32'd1227133514, 32'd1073741824, 32'd1908874354, 32'd1717986919
	};
	localparam logic [5:0] DIV_SHIFT [1:10] = '{
		6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34
	};

	localparam logic [16:0] CUM_ONE  = 17'd65536;
	localparam logic [16:0] CUM_HALF = 17'd32768;

	// Everything one item carries down the pipeline.
	typedef struct packed {
		logic        neg;
		logic        dz;
		logic        inv;
		logic        far;
		logic [32:0] ad;
		logic [60:0] rem;
		logic [31:0] quo;
		logic [31:0] z28;
		logic [32:0] dt;
		logic [30:0] t30;
		logic [35:0] poly;
		logic [35:0] ex;
		logic [7:0]  k;
		logic [29:0] y30;
		logic [30:0] r;
		logic [28:0] phi30;
		logic [60:0] dsor;
		logic        big;
		logic        sat;
		logic [63:0] prod;
		logic [31:0] dens;
		logic [16:0] cum;
	} item_t;

endpackage

// ===== sv/gpc_pipe.sv =====
`timescale 1ns / 1ps
// Datapath pipeline of the Gaussian density and CDF block: long divisions,
// exponential and tail polynomial, one stage per step. Depends on gpc_pkg.

module gpc_pipe #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] abscissa,
	input  logic [31:0] mean,
	input  logic [30:0] std_dev,
	output logic        out_valid,
	output logic [31:0] density,
	output logic [16:0] cumulative,
	output logic        invalid
);

	localparam int ZDIV_N  = 32;
	localparam int TDIV_N  = 31;
	localparam int POLY_N  = 5;
	localparam int HORN_N  = 10;
	localparam int DDIV_N  = 32;
	localparam int S_ZDIV  = 1;
	localparam int S_TPREP = S_ZDIV + ZDIV_N;
	localparam int S_TDIV  = S_TPREP + 1;
	localparam int S_POLY  = S_TDIV + TDIV_N;
	localparam int S_EXP0  = S_POLY + POLY_N;
	localparam int S_EXP1  = S_EXP0 + 1;
	localparam int S_EXP2  = S_EXP1 + 1;
	localparam int S_HORN  = S_EXP2 + 1;
	localparam int S_PHI   = S_HORN + 2 * HORN_N;
	localparam int S_DPREP = S_PHI + 1;
	localparam int S_DDIV  = S_DPREP + 1;
	localparam int S_TAIL  = S_DDIV + DDIV_N;
	localparam int S_OUT   = S_TAIL + 1;
	localparam int NST     = S_OUT + 1;
	localparam int SHIFT_BASE = 62 - 2 * FRAC_BITS;

	gpc_pkg::item_t st [NST];
	gpc_pkg::item_t nx [NST];
	logic [NST-1:0] vld_q;

	function automatic gpc_pkg::item_t f_entry(logic [31:0] x, logic [31:0] mu,
		logic [30:0] sg);
		gpc_pkg::item_t o;
		logic [32:0] d;
		o = '0;
		d = {x[31], x} - {mu[31], mu};
		o.neg = d[32];
		o.dz = (d == '0);
		o.inv = (sg == '0);
		o.ad = d[32] ? (~d + 33'd1) : d;
		o.far = ({3'b0, o.ad} >= {1'b0, sg, 4'b0});
		o.rem = 61'(o.ad >> 4);
		return o;
	endfunction

	// One quotient bit of |x - mean| * 2^28 / std_dev.
	function automatic gpc_pkg::item_t f_zdiv(gpc_pkg::item_t c, logic [30:0] sg);
		gpc_pkg::item_t o;
		logic [31:0] r2;
		o = c;
		r2 = {c.rem[30:0], c.ad[3]};
		o.ad = c.ad << 1;
		if (r2 >= {1'b0, sg}) begin
			o.rem = 61'(r2 - {1'b0, sg});
			o.quo = {c.quo[30:0], 1'b1};
		end else begin
			o.rem = 61'(r2);
			o.quo = {c.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_tprep(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [59:0] pz;
		o = c;
		o.z28 = c.quo;
		pz = {28'b0, c.quo} * {32'b0, gpc_pkg::P_Q30};
		o.dt = 33'(gpc_pkg::ONE30) + {1'b0, pz[59:28]};
		o.rem = 61'(1) << 29;
		o.quo = '0;
		return o;
	endfunction

	// One quotient bit of 2^60 / (2^30 + p*z).
	function automatic gpc_pkg::item_t f_tdiv(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [33:0] r2;
		o = c;
		r2 = {c.rem[32:0], 1'b0};
		if (r2 >= {1'b0, c.dt}) begin
			o.rem = 61'(r2 - {1'b0, c.dt});
			o.quo = {c.quo[30:0], 1'b1};
		end else begin
			o.rem = 61'(r2);
			o.quo = {c.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	// One Horner step of the tail polynomial; products truncate toward zero.
	function automatic gpc_pkg::item_t f_poly(gpc_pkg::item_t c, logic first,
		logic [35:0] add);
		gpc_pkg::item_t o;
		logic [35:0] a;
		logic [30:0] t;
		logic [33:0] mag;
		logic [64:0] pr;
		logic [35:0] sm;
		o = c;
		a = first ? gpc_pkg::B5_Q30 : c.poly;
		t = first ? c.quo[30:0] : c.t30;
		o.t30 = t;
		mag = a[35] ? 34'(-a) : a[33:0];
		pr = {31'b0, mag} * {34'b0, t};
		sm = a[35] ? -{1'b0, pr[64:30]} : {1'b0, pr[64:30]};
		o.poly = add + sm;
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_exp0(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [63:0] sq;
		o = c;
		if (c.poly[35]) begin
			o.poly = '0;
		end
		sq = {32'b0, c.z28} * {32'b0, c.z28};
		o.ex = {1'b0, sq[63:29]};
		return o;
	endfunction

	// Split z^2/2 * log2(e) into an integer power of two and a fraction.
	function automatic gpc_pkg::item_t f_exp1(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [63:0] u;
		o = c;
		u = {29'b0, c.ex[34:0]} * {35'b0, gpc_pkg::LOG2E_Q28};
		o.k = u[63:56];
		o.y30 = {u[55:28], 2'b00};
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_exp2(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [59:0] m;
		o = c;
		m = {30'b0, c.y30} * {30'b0, gpc_pkg::LN2_Q30};
		o.y30 = m[59:30];
		o.r = gpc_pkg::ONE30;
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_hmul(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [60:0] m;
		o = c;
		m = {31'b0, c.y30} * {30'b0, c.r};
		o.ex = 36'(m[60:30]);
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_hdiv(gpc_pkg::item_t c, logic [31:0] recip,
		logic [5:0] sh);
		gpc_pkg::item_t o;
		logic [61:0] hp;
		logic [61:0] q;
		o = c;
		hp = {32'b0, c.ex[29:0]} * {30'b0, recip};
		q = hp >> sh;
		o.r = gpc_pkg::ONE30 - q[30:0];
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_phi(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [59:0] m;
		o = c;
		m = {29'b0, c.r} * {31'b0, gpc_pkg::INV_SQRT2PI_Q30};
		o.phi30 = m[58:30];
		return o;
	endfunction

	// Density divisor is std_dev << (62 - 2*FRAC_BITS + k); a divisor at or
	// above 2^61 exceeds any dividend and gives zero.
	function automatic gpc_pkg::item_t f_dprep(gpc_pkg::item_t c, logic [30:0] sg);
		gpc_pkg::item_t o;
		logic [8:0]  s;
		logic [92:0] df;
		o = c;
		s = 9'(SHIFT_BASE) + {1'b0, c.k};
		df = {62'b0, sg} << s[5:0];
		o.big = (s >= 9'd61) || (|df[92:61]);
		o.dsor = df[60:0];
		o.sat = !o.big && ({32'b0, c.phi30} >= df[60:0]);
		o.rem = {32'b0, c.phi30};
		o.quo = '0;
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_ddiv(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [61:0] r2;
		o = c;
		r2 = {c.rem, 1'b0};
		if (r2 >= {1'b0, c.dsor}) begin
			o.rem = 61'(r2 - {1'b0, c.dsor});
			o.quo = {c.quo[30:0], 1'b1};
		end else begin
			o.rem = r2[60:0];
			o.quo = {c.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_tail(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		o = c;
		if (c.big) begin
			o.dens = '0;
		end else if (c.sat) begin
			o.dens = '1;
		end else begin
			o.dens = c.quo;
		end
		o.prod = {35'b0, c.phi30} * {29'b0, c.poly[34:0]};
		return o;
	endfunction

	function automatic gpc_pkg::item_t f_out(gpc_pkg::item_t c);
		gpc_pkg::item_t o;
		logic [5:0]  ts;
		logic [64:0] sum;
		logic [64:0] sh;
		logic [16:0] tl;
		o = c;
		ts = 6'(7'd44 + {2'b0, c.k[4:0]});
		sum = {1'b0, c.prod} + (65'd1 << (ts - 6'd1));
		sh = sum >> ts;
		if (c.k >= 8'd20) begin
			tl = '0;
		end else if (sh >= 65'(gpc_pkg::CUM_ONE)) begin
			tl = gpc_pkg::CUM_ONE;
		end else begin
			tl = sh[16:0];
		end
		o.cum = c.neg ? tl : (gpc_pkg::CUM_ONE - tl);
		if (c.inv) begin
			o.dens = '1;
			o.cum = c.neg ? '0 : (c.dz ? gpc_pkg::CUM_HALF : gpc_pkg::CUM_ONE);
		end else if (c.far) begin
			o.dens = '0;
			o.cum = c.neg ? '0 : gpc_pkg::CUM_ONE;
		end
		return o;
	endfunction

	assign nx[0] = f_entry(abscissa, mean, std_dev);

	for (genvar j = 0; j < ZDIV_N; j++) begin : g_zdiv
		assign nx[S_ZDIV + j] = f_zdiv(st[S_ZDIV + j - 1], std_dev);
	end

	assign nx[S_TPREP] = f_tprep(st[S_TPREP - 1]);

	for (genvar j = 0; j < TDIV_N; j++) begin : g_tdiv
		assign nx[S_TDIV + j] = f_tdiv(st[S_TDIV + j - 1]);
	end

	for (genvar j = 0; j < POLY_N; j++) begin : g_poly
		assign nx[S_POLY + j] = f_poly(st[S_POLY + j - 1], 1'(j == 0), gpc_pkg::POLY_ADD[j]);
	end

	assign nx[S_EXP0] = f_exp0(st[S_EXP0 - 1]);
	assign nx[S_EXP1] = f_exp1(st[S_EXP1 - 1]);
	assign nx[S_EXP2] = f_exp2(st[S_EXP2 - 1]);

	// Taylor series of exp(-y), innermost divisor first.
	for (genvar j = 0; j < HORN_N; j++) begin : g_horn
		assign nx[S_HORN + 2*j] = f_hmul(st[S_HORN + 2*j - 1]);
		assign nx[S_HORN + 2*j + 1] = f_hdiv(st[S_HORN + 2*j],
			gpc_pkg::DIV_RECIP[HORN_N - j], gpc_pkg::DIV_SHIFT[HORN_N - j]);
	end

	assign nx[S_PHI]   = f_phi(st[S_PHI - 1]);
	assign nx[S_DPREP] = f_dprep(st[S_DPREP - 1], std_dev);

	for (genvar j = 0; j < DDIV_N; j++) begin : g_ddiv
		assign nx[S_DDIV + j] = f_ddiv(st[S_DDIV + j - 1]);
	end

	assign nx[S_TAIL] = f_tail(st[S_TAIL - 1]);
	assign nx[S_OUT]  = f_out(st[S_OUT - 1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) begin
				st[i] <= nx[i];
			end
		end
	end

	assign out_valid  = vld_q[NST-1];
	assign density    = st[NST-1].dens;
	assign cumulative = st[NST-1].cum;
	assign invalid    = st[NST-1].inv;

`ifndef SYNTHESIS
	a_cum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cumulative <= gpc_pkg::CUM_ONE)
		else $error("cumulative above one");
	a_inv_dens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> density == 32'hFFFF_FFFF)
		else $error("invalid item without saturated density");
	a_inv_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> std_dev == '0)
		else $error("invalid item with nonzero deviation");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");
`endif

endmodule

// ===== sv/gaussian_pdf_cdf.sv =====
`timescale 1ns / 1ps
// Top level of the Gaussian density and CDF block: configuration registers,
// handshake and the gpc_pipe datapath. Depends on gpc_pkg and gpc_pipe.

// Each item is an abscissa x; the block returns the normal density and the
// cumulative probability (Abramowitz-Stegun 26.2.17) for the configured mean
// and standard deviation. One item enters every clock cycle while in_ready
// is high; the pipeline depth is set by the three bit-per-stage long
// divisions (z, the polynomial argument t and the density quotient) and the
// exponential series up to the tenth power. When a result waits at the
// output and out_ready is low, the whole pipeline holds and in_ready drops.
// Write mean and std_dev only while no item is in flight.

module gaussian_pdf_cdf #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] abscissa,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] density,
	output logic [16:0] cumulative,
	output logic        invalid
);

	logic [31:0] mean_q;
	logic [30:0] std_dev_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q    <= '0;
			std_dev_q <= gpc_pkg::STD_DEV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gpc_pkg::REG_MEAN:    mean_q    <= cfg_wdata;
				gpc_pkg::REG_STD_DEV: std_dev_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	gpc_pipe #(
		.FRAC_BITS (FRAC_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.abscissa   (abscissa),
		.mean       (mean_q),
		.std_dev    (std_dev_q),
		.out_valid  (out_valid),
		.density    (density),
		.cumulative (cumulative),
		.invalid    (invalid)
	);

endmodule
